@@ hw/rtl/fxalu_pkg.sv @@
// Opcode, status codes and default sizes for the fixed-point ALU.
package fxalu_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int WORD_BITS_DEF = 32;
    localparam int OP_BITS       = 4;
    localparam int STATUS_BITS   = 2;

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD = 4'd0,
        OP_SUB = 4'd1,
        OP_MUL = 4'd2,
        OP_DIV = 4'd3,
        OP_LT  = 4'd4,
        OP_GT  = 4'd5,
        OP_LE  = 4'd6,
        OP_GE  = 4'd7,
        OP_EQ  = 4'd8,
        OP_NE  = 4'd9,
        OP_MIN = 4'd10,
        OP_MAX = 4'd11,
        OP_INC = 4'd12,
        OP_DEC = 4'd13
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } status_t;

endpackage

@@ hw/rtl/fixed_point_q24_8_alu_unit.sv @@
// Signed fixed-point ALU (Q24.8 by default), fully pipelined, with a bit-per-stage divider.
//
// Takes one transaction every cycle unless the output stalls, and returns one result
// per transaction, in order. The pipeline is an input register, an operand stage with
// the multiplier, a rounding stage, one divider stage for each quotient bit, and an
// output register. Every operation travels the whole pipeline; a stall at the output
// holds every stage. Opcode in tuser; add, sub, mul and div round to nearest with
// ties upward and saturate on overflow; divide by zero saturates with the sign of
// the dividend.
module fixed_point_q24_8_alu_unit #(
    parameter int FRAC_BITS = fxalu_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = fxalu_pkg::WORD_BITS_DEF,
    parameter int IN_DW     = ((2 * WORD_BITS + 7) / 8) * 8,
    parameter int OUT_DW    = ((WORD_BITS + 3 + 7) / 8) * 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [IN_DW-1:0]             s_axis_tdata,  // a, b
    input  logic [fxalu_pkg::OP_BITS-1:0] s_axis_tuser, // op
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [OUT_DW-1:0]            m_axis_tdata   // value, cmp, status
);
    import fxalu_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int NB = WORD_BITS + FRAC_BITS;

    logic en;

    logic         v1_reg;
    op_t          op1_reg;
    logic [W-1:0] a1_reg, b1_reg;

    logic           v2_reg;
    op_t            op2_reg;
    logic [W-1:0]   val2_reg, val2_next;
    logic           cmp2_reg, cmp2_next;
    status_t        st2_reg, st2_next;
    logic [2*W-1:0] prod2_reg;
    logic           neg2_reg, sa2_reg;
    logic [W-1:0]   ma2_reg, mb2_reg, ma2_next, mb2_next;

    logic          v_reg    [0:NB];
    logic [W-1:0]  val_reg  [0:NB];
    logic          cmp_reg  [0:NB];
    status_t       st_reg   [0:NB];
    logic          div_reg  [0:NB];
    logic          neg_reg  [0:NB];
    logic [W-1:0]  rem_reg  [0:NB];
    logic [NB-1:0] num_reg  [0:NB];
    logic [W-1:0]  d_reg    [0:NB];

    logic [W-1:0]  val0_next;
    status_t       st0_next;
    logic [W-1:0]  rem_next [1:NB];
    logic [NB-1:0] num_next [1:NB];

    logic              out_v_reg;
    logic [W-1:0]      out_val_reg, out_val_next;
    logic              out_cmp_reg;
    status_t           out_st_reg, out_st_next;

    logic [W-1:0]   sum, dif, bsel;
    logic           lt;
    logic [2*W-1:0] mq, mlim;
    logic           minc;
    logic [W-1:0]   drem_diff;
    logic           dinc;
    logic [NB:0]    dq, dlim;

    function automatic logic [W-1:0] sat_val(input logic neg);
        return neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    endfunction

    assign en            = !out_v_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            for (int k = 0; k <= NB; k++)
            begin
                v_reg[k] <= 1'b0;
            end
            out_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v_reg[0] <= v2_reg;
            for (int k = 1; k <= NB; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
            out_v_reg <= v_reg[NB];
        end
    end

    always_comb
    begin
        bsel = (op1_reg == OP_INC || op1_reg == OP_DEC) ? {{(W-1){1'b0}}, 1'b1} : b1_reg;
        sum  = a1_reg + bsel;
        dif  = a1_reg - bsel;
        lt   = $signed(a1_reg) < $signed(b1_reg);
        ma2_next = a1_reg[W-1] ? (~a1_reg + 1'b1) : a1_reg;
        mb2_next = b1_reg[W-1] ? (~b1_reg + 1'b1) : b1_reg;
        val2_next = '0;
        cmp2_next = 1'b0;
        st2_next  = ST_OK;
        case (op1_reg)
            OP_ADD, OP_INC:
            begin
                if (a1_reg[W-1] == bsel[W-1] && sum[W-1] != a1_reg[W-1])
                begin
                    val2_next = sat_val(a1_reg[W-1]);
                    st2_next  = ST_SAT;
                end
                else
                begin
                    val2_next = sum;
                end
            end
            OP_SUB, OP_DEC:
            begin
                if (a1_reg[W-1] != bsel[W-1] && dif[W-1] != a1_reg[W-1])
                begin
                    val2_next = sat_val(a1_reg[W-1]);
                    st2_next  = ST_SAT;
                end
                else
                begin
                    val2_next = dif;
                end
            end
            OP_LT:   cmp2_next = lt;
            OP_GT:   cmp2_next = !lt && (a1_reg != b1_reg);
            OP_LE:   cmp2_next = lt || (a1_reg == b1_reg);
            OP_GE:   cmp2_next = !lt;
            OP_EQ:   cmp2_next = a1_reg == b1_reg;
            OP_NE:   cmp2_next = a1_reg != b1_reg;
            OP_MIN:  val2_next = lt ? a1_reg : b1_reg;
            OP_MAX:  val2_next = (!lt && (a1_reg != b1_reg)) ? a1_reg : b1_reg;
            default: val2_next = '0;
        endcase
    end

    always_comb
    begin
        mq   = prod2_reg >> FRAC_BITS;
        minc = neg2_reg ? (prod2_reg[FRAC_BITS-1:0] > (FRAC_BITS)'(1 << (FRAC_BITS - 1)))
                        : (prod2_reg[FRAC_BITS-1:0] >= (FRAC_BITS)'(1 << (FRAC_BITS - 1)));
        mq   = mq + (2*W)'(minc);
        mlim = neg2_reg ? (2*W)'({1'b1, {(W-1){1'b0}}}) : (2*W)'({1'b0, {(W-1){1'b1}}});
        val0_next = val2_reg;
        st0_next  = st2_reg;
        if (op2_reg == OP_MUL)
        begin
            if (mq > mlim)
            begin
                val0_next = sat_val(neg2_reg);
                st0_next  = ST_SAT;
            end
            else
            begin
                val0_next = neg2_reg ? (~mq[W-1:0] + 1'b1) : mq[W-1:0];
                st0_next  = ST_OK;
            end
        end
        else if (op2_reg == OP_DIV && mb2_reg == '0)
        begin
            val0_next = sat_val(sa2_reg);
            st0_next  = ST_DIVZ;
        end
    end

    always_comb
    begin
        logic [W:0] t;
        logic       ge;
        for (int k = 1; k <= NB; k++)
        begin
            t  = {rem_reg[k-1], num_reg[k-1][NB-1]};
            ge = t >= {1'b0, d_reg[k-1]};
            rem_next[k] = ge ? W'(t - {1'b0, d_reg[k-1]}) : t[W-1:0];
            num_next[k] = {num_reg[k-1][NB-2:0], ge};
        end
    end

    always_comb
    begin
        drem_diff = d_reg[NB] - rem_reg[NB];
        dinc = neg_reg[NB] ? (rem_reg[NB] > drem_diff) : (rem_reg[NB] >= drem_diff);
        dq   = {1'b0, num_reg[NB]} + (NB+1)'(dinc);
        dlim = neg_reg[NB] ? (NB+1)'({1'b1, {(W-1){1'b0}}}) : (NB+1)'({1'b0, {(W-1){1'b1}}});
        out_val_next = val_reg[NB];
        out_st_next  = st_reg[NB];
        if (div_reg[NB])
        begin
            if (dq > dlim)
            begin
                out_val_next = sat_val(neg_reg[NB]);
                out_st_next  = ST_SAT;
            end
            else
            begin
                out_val_next = neg_reg[NB] ? (~dq[W-1:0] + 1'b1) : dq[W-1:0];
                out_st_next  = ST_OK;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg <= op_t'(s_axis_tuser);
            a1_reg  <= s_axis_tdata[W-1:0];
            b1_reg  <= s_axis_tdata[2*W-1:W];

            op2_reg   <= op1_reg;
            val2_reg  <= val2_next;
            cmp2_reg  <= cmp2_next;
            st2_reg   <= st2_next;
            prod2_reg <= ma2_next * mb2_next;
            neg2_reg  <= a1_reg[W-1] ^ b1_reg[W-1];
            sa2_reg   <= a1_reg[W-1];
            ma2_reg   <= ma2_next;
            mb2_reg   <= mb2_next;

            val_reg[0] <= val0_next;
            cmp_reg[0] <= cmp2_reg;
            st_reg[0]  <= st0_next;
            div_reg[0] <= (op2_reg == OP_DIV) && (mb2_reg != '0);
            neg_reg[0] <= neg2_reg;
            rem_reg[0] <= '0;
            num_reg[0] <= {ma2_reg, {FRAC_BITS{1'b0}}};
            d_reg[0]   <= mb2_reg;
            for (int k = 1; k <= NB; k++)
            begin
                val_reg[k] <= val_reg[k-1];
                cmp_reg[k] <= cmp_reg[k-1];
                st_reg[k]  <= st_reg[k-1];
                div_reg[k] <= div_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                rem_reg[k] <= rem_next[k];
                num_reg[k] <= num_next[k];
                d_reg[k]   <= d_reg[k-1];
            end

            out_val_reg <= out_val_next;
            out_cmp_reg <= cmp_reg[NB];
            out_st_reg  <= out_st_next;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = OUT_DW'({out_st_reg, out_cmp_reg, out_val_reg});

endmodule
